FILE: rtl/shp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shp_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned PROD_W        = 64;
	localparam int unsigned ORD_W         = 4;
	localparam int unsigned CFG_INDEX_W   = 3;
	localparam int unsigned NUM_COEF_REGS = 6;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_LOWEST_ORDER = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SHIFT        = 3'd7;

	localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd32768;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] d;
		logic signed [DATA_W-1:0] acc;
		logic                     ovf;
	} shp_word_t;

	function automatic logic ovf33(input logic [DATA_W:0] v);
		return v[DATA_W] != v[DATA_W-1];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? S32_MIN : S32_MAX;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/shifted_polynomial_horner.sv
`timescale 1ns / 1ps
`default_nettype none

// Shifted polynomial evaluator, signed Q16.16. For each word x_value it forms
// d = x_value - shift, evaluates coef_0 + coef_1*d + ... by Horner's rule, multiplies
// the result by d once per unit of lowest_order (capped at MAX_LOWEST_ORDER), and adds
// 1.0 when that order is nonzero. Products round to nearest, ties up; every step
// saturates and sets overflow. One word enters per cycle while the pipeline is not
// stalled. Each Horner step and each power step has one multiply stage and one
// round/add stage. An output stall while out_valid is high freezes the whole pipeline.
// Configuration registers: 0..5 coef_0..coef_5, 6 lowest_order, 7 shift; write them
// only while the pipeline is empty.
module shifted_polynomial_horner #(
	parameter int unsigned NUM_COEFS        = 6,
	parameter int unsigned MAX_LOWEST_ORDER = 7
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [shp_pkg::DATA_W-1:0] x_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [shp_pkg::DATA_W-1:0]      value,
	output logic                                   overflow,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [shp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [shp_pkg::DATA_W-1:0]        cfg_data
);
	import shp_pkg::*;

	localparam int unsigned NHORN = NUM_COEFS - 1;
	localparam int unsigned NSTEP = NHORN + MAX_LOWEST_ORDER;

	logic signed [DATA_W-1:0] coef [NUM_COEFS];
	logic [2:0]               lowest_order;
	logic signed [DATA_W-1:0] shift;
	logic [ORD_W-1:0]         ord;
	logic                     adv;
	logic [DATA_W:0]          diff;
	shp_word_t                seed_s1;
	shp_word_t                chain [NSTEP+1];
	shp_word_t                fin_s;
	logic [DATA_W:0]          fin_sum;

	shp_cfg #(
		.NUM_COEFS(NUM_COEFS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.coef        (coef),
		.lowest_order(lowest_order),
		.shift       (shift)
	);

	assign ord = (ORD_W'(lowest_order) > ORD_W'(MAX_LOWEST_ORDER)) ?
		ORD_W'(MAX_LOWEST_ORDER) : ORD_W'(lowest_order);

	// advance everything unless the result register is full and held
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: saturating subtract, seed the top coefficient
	assign diff = {x_value[DATA_W-1], x_value} - {shift[DATA_W-1], shift};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_s1 <= '0;
		end else if (adv) begin
			seed_s1.valid <= in_valid;
			seed_s1.d     <= sat33(diff);
			seed_s1.acc   <= coef[NUM_COEFS-1];
			seed_s1.ovf   <= ovf33(diff);
		end
	end

	assign chain[0] = seed_s1;

	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		logic signed [DATA_W-1:0] addend;
		logic                     use_mul;
		if (j < NHORN) begin : g_horn
			assign addend  = coef[NHORN-1-j];
			assign use_mul = 1'b1;
		end else begin : g_pow
			assign addend  = '0;
			assign use_mul = ORD_W'(j - NHORN) < ord;
		end
		shp_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.in_w   (chain[j]),
			.addend (addend),
			.use_mul(use_mul),
			.out_w  (chain[j+1])
		);
	end

	// final stage: add one for a nonzero order
	assign fin_sum = {chain[NSTEP].acc[DATA_W-1], chain[NSTEP].acc} +
		{Q_ONE[DATA_W-1], Q_ONE};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s <= '0;
		end else if (adv) begin
			fin_s.valid <= chain[NSTEP].valid;
			fin_s.d     <= chain[NSTEP].d;
			if (ord != '0) begin
				fin_s.acc <= sat33(fin_sum);
				fin_s.ovf <= chain[NSTEP].ovf | ovf33(fin_sum);
			end else begin
				fin_s.acc <= chain[NSTEP].acc;
				fin_s.ovf <= chain[NSTEP].ovf;
			end
		end
	end

	assign out_valid = fin_s.valid;
	assign value     = fin_s.acc;
	assign overflow  = fin_s.ovf;

endmodule

`default_nettype wire

FILE: rtl/shp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module shp_cfg #(
	parameter int unsigned NUM_COEFS = 6
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [shp_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [shp_pkg::DATA_W-1:0]             cfg_data,
	output logic signed [shp_pkg::DATA_W-1:0]           coef [NUM_COEFS],
	output logic [2:0]                                  lowest_order,
	output logic signed [shp_pkg::DATA_W-1:0]           shift
);
	import shp_pkg::*;

	logic signed [DATA_W-1:0] coef_q [NUM_COEFS];
	logic [2:0]               lowest_order_q;
	logic signed [DATA_W-1:0] shift_q;
	logic                     wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	// coefficient slots past NUM_COEFS are not stored: writes there drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
			lowest_order_q <= '0;
			shift_q        <= '0;
		end else if (wr) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				if (cfg_index == CFG_INDEX_W'(i)) begin
					coef_q[i] <= cfg_data;
				end
			end
			if (cfg_index == REG_LOWEST_ORDER) begin
				lowest_order_q <= cfg_data[2:0];
			end
			if (cfg_index == REG_SHIFT) begin
				shift_q <= cfg_data;
			end
		end
	end

	assign coef         = coef_q;
	assign lowest_order = lowest_order_q;
	assign shift        = shift_q;

endmodule

`default_nettype wire

FILE: rtl/shp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module shp_step (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire shp_pkg::shp_word_t                in_w,
	input  wire logic signed [shp_pkg::DATA_W-1:0] addend,
	input  wire logic                              use_mul,
	output shp_pkg::shp_word_t                     out_w
);
	import shp_pkg::*;

	shp_word_t                w_s1;
	logic signed [PROD_W-1:0] prod_s1;
	shp_word_t                w_s2;

	logic signed [PROD_W-1:0] rnd;
	logic [PROD_W-17:0]       q;
	logic                     q_ovf;
	logic signed [DATA_W-1:0] r32;
	logic [DATA_W:0]          sum;
	shp_word_t                nxt;

	// stage 1: full product of d and the running value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_s1    <= '0;
			prod_s1 <= '0;
		end else if (adv) begin
			w_s1    <= in_w;
			prod_s1 <= PROD_W'(in_w.d) * PROD_W'(in_w.acc);
		end
	end

	// stage 2: round to nearest (ties up), saturate, add, saturate; without use_mul the word passes unchanged
	always_comb begin
		rnd   = prod_s1 + RND_HALF;
		q     = rnd[PROD_W-1:16];
		q_ovf = !((&q[PROD_W-17:DATA_W-1]) || !(|q[PROD_W-17:DATA_W-1]));
		if (q_ovf) begin
			r32 = q[PROD_W-17] ? S32_MIN : S32_MAX;
		end else begin
			r32 = q[DATA_W-1:0];
		end
		sum = {r32[DATA_W-1], r32} + {addend[DATA_W-1], addend};
		nxt = w_s1;
		if (use_mul) begin
			nxt.acc = sat33(sum);
			nxt.ovf = w_s1.ovf | q_ovf | ovf33(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_s2 <= '0;
		end else if (adv) begin
			w_s2 <= nxt;
		end
	end

	assign out_w = w_s2;

endmodule

`default_nettype wire
